// ----- rtl/ifs_pkg.sv -----
// ----------------------------------------------------------------------------
// ifs_pkg
// shared types, constants and result builders for the image frame sender
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int ROW_CAPACITY = 256;
    localparam int ROW_AW       = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int MAX_RES      = 8;
    localparam int RES_IW       = $clog2(MAX_RES);
    localparam int RES_CW       = $clog2(MAX_RES + 1);
    localparam logic [7:0] ESCAPE_BYTE = 8'd170;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 8;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_REPLY = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_ACK       = 2'd0,
        CFG_FUNCTION  = 2'd1,
        CFG_END_IMAGE = 2'd2,
        CFG_END_ROW   = 2'd3
    } t_cfg_reg;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_HDR_WAIT = 5'b00010,
        PH_PIXELS   = 5'b00100,
        PH_ROW_WAIT = 5'b01000,
        PH_REPLAY   = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        K_REJECT = 3'd0,
        K_HEADER = 3'd1,
        K_COLOUR = 3'd2,
        K_EMPTY  = 3'd3,
        K_DONE   = 3'd4
    } t_kind;

    // byte list for one transaction burst
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [RES_CW-1:0]       count;
        logic                    tx_valid;
        logic                    rejected;
        logic                    image_done;
    } t_job;

    function automatic t_job ifs_colour_job(input logic [23:0] rgb,
                                            input logic        trailer,
                                            input logic [7:0]  func_code,
                                            input logic [7:0]  end_code);
        t_job              j;
        logic [RES_CW-1:0] n;
        logic [7:0]        c;
        j = '0;
        n = '0;
        for (int k = 2; k >= 0; k--) begin
            c = rgb[k*8 +: 8];
            j.bytes[n[RES_IW-1:0]] = c;
            n = n + RES_CW'(1);
            if (c == ESCAPE_BYTE) begin
                j.bytes[n[RES_IW-1:0]] = c;
                n = n + RES_CW'(1);
            end
        end
        if (trailer) begin
            j.bytes[n[RES_IW-1:0]] = func_code;
            n = n + RES_CW'(1);
            j.bytes[n[RES_IW-1:0]] = end_code;
            n = n + RES_CW'(1);
        end
        j.count    = n;
        j.tx_valid = 1'b1;
        return j;
    endfunction

    function automatic t_job ifs_single_job(input logic rejected, input logic done);
        t_job j;
        j            = '0;
        j.count      = RES_CW'(1);
        j.rejected   = rejected;
        j.image_done = done;
        return j;
    endfunction

    function automatic t_job ifs_header_job(input logic [23:0] hdr);
        t_job j;
        j          = '0;
        j.bytes[0] = hdr[7:0];
        j.bytes[1] = hdr[15:8];
        j.bytes[2] = hdr[23:16];
        j.count    = RES_CW'(3);
        j.tx_valid = 1'b1;
        return j;
    endfunction

endpackage

// ----- rtl/image_frame_sender_core.sv -----
// ----------------------------------------------------------------------------
// image_frame_sender_core
// sends an rgb image as a byte stream with per-row acknowledge and row replay
// ----------------------------------------------------------------------------
// Each input transaction is decoded and turned into a list of one to eight
// output bytes, which leave at one transaction per cycle while m_tready is
// high; a header, also one resent on a non-ack reply, gives three bytes, a
// pixel or replay tick three to eight, any other item one, and a new input
// is taken while the previous list is still being sent. Pixels are kept in
// a 256 x 24 row memory; a replay tick reads it through the registered read
// port, whose data feeds the tick's byte list once the decoded tick is registered.
// Configuration is plain write-only: index 0 ack code, 1 function code,
// 2 end-of-image code, 3 end-of-row code.
module image_frame_sender_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel, width, height, pixel_rgb, rx_byte
    input  logic [ifs_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [ifs_pkg::S_TUSER_W-1:0]       s_tuser,  // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ifs_pkg::M_TDATA_W-1:0]       m_tdata,  // tx_byte
    output logic [ifs_pkg::M_TUSER_W-1:0]       m_tuser,  // tx_valid, rejected, image_done
    output logic                                m_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [ifs_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [ifs_pkg::CFG_DW-1:0]          i_cfg_wdata
);
    import ifs_pkg::*;

    logic [7:0]  r_ack_code, r_func_code, r_end_img_code, r_end_row_code;

    t_phase      r_phase, n_phase;
    logic [ROW_AW-1:0] r_col, n_col;
    logic [ROW_AW-1:0] r_replay, n_replay;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_width, n_width;
    logic [7:0]  r_height, n_height;
    logic [7:0]  r_channel, n_channel;

    logic        r_s1_valid, n_s1_valid;
    t_kind       r_s1_kind, n_s1_kind;
    logic [23:0] r_s1_hdr, n_s1_hdr;
    logic [23:0] r_s1_rgb, n_s1_rgb;
    logic        r_s1_from_ram, n_s1_from_ram;
    logic        r_s1_trailer, n_s1_trailer;
    logic [7:0]  r_s1_end, n_s1_end;

    t_req        w_req;
    logic [7:0]  w_ch, w_w, w_h, w_rx;
    logic [23:0] w_rgb;
    logic        w_accept;
    logic        w_job_ready;
    logic        w_last_row;
    logic        w_ram_we, w_ram_re;
    logic [23:0] w_ram_rdata;
    t_job        w_job;

    assign w_req = t_req'(s_tuser);
    assign w_ch  = s_tdata[7:0];
    assign w_w   = s_tdata[15:8];
    assign w_h   = s_tdata[23:16];
    assign w_rgb = s_tdata[47:24];
    assign w_rx  = s_tdata[55:48];

    assign s_tready   = !r_s1_valid || w_job_ready;
    assign w_accept   = s_tvalid && s_tready;
    assign w_last_row = ({1'b0, r_row} + 9'd1) == {1'b0, r_height};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code     <= 8'd6;
            r_func_code    <= 8'd170;
            r_end_img_code <= 8'd1;
            r_end_row_code <= 8'd2;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ACK:       r_ack_code     <= i_cfg_wdata;
                CFG_FUNCTION:  r_func_code    <= i_cfg_wdata;
                CFG_END_IMAGE: r_end_img_code <= i_cfg_wdata;
                CFG_END_ROW:   r_end_row_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // decode and state update
    always_comb begin
        n_phase       = r_phase;
        n_col         = r_col;
        n_replay      = r_replay;
        n_row         = r_row;
        n_width       = r_width;
        n_height      = r_height;
        n_channel     = r_channel;
        n_s1_valid    = w_job_ready ? 1'b0 : r_s1_valid;
        n_s1_kind     = r_s1_kind;
        n_s1_hdr      = r_s1_hdr;
        n_s1_rgb      = r_s1_rgb;
        n_s1_from_ram = r_s1_from_ram;
        n_s1_trailer  = r_s1_trailer;
        n_s1_end      = r_s1_end;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;
        if (w_accept) begin
            n_s1_valid    = 1'b1;
            n_s1_kind     = K_REJECT;
            n_s1_from_ram = 1'b0;
            n_s1_trailer  = 1'b0;
            n_s1_end      = w_last_row ? r_end_img_code : r_end_row_code;
            n_s1_hdr      = {r_height, r_width, r_channel};
            n_s1_rgb      = w_rgb;
            unique case (w_req)
                REQ_START: begin
                    if (r_phase == PH_IDLE && w_w != '0 && w_h != '0
                        && int'(w_w) <= ROW_CAPACITY) begin
                        n_channel = w_ch;
                        n_width   = w_w;
                        n_height  = w_h;
                        n_col     = '0;
                        n_row     = '0;
                        n_replay  = '0;
                        n_phase   = PH_HDR_WAIT;
                        n_s1_kind = K_HEADER;
                        n_s1_hdr  = {w_h, w_w, w_ch};
                    end
                end
                REQ_PIXEL: begin
                    if (r_phase == PH_PIXELS && int'(r_col) < ROW_CAPACITY) begin
                        w_ram_we  = 1'b1;
                        n_s1_kind = K_COLOUR;
                        if (({1'b0, r_col} + 9'd1) >= {1'b0, r_width}) begin
                            n_s1_trailer = 1'b1;
                            n_col        = '0;
                            n_phase      = PH_ROW_WAIT;
                        end else begin
                            n_col = r_col + ROW_AW'(1);
                        end
                    end
                end
                REQ_REPLY: begin
                    if (r_phase == PH_HDR_WAIT) begin
                        if (w_rx == r_ack_code) begin
                            n_col     = '0;
                            n_row     = '0;
                            n_phase   = PH_PIXELS;
                            n_s1_kind = K_EMPTY;
                        end else begin
                            n_s1_kind = K_HEADER;
                        end
                    end else if (r_phase == PH_ROW_WAIT) begin
                        if (w_rx == r_ack_code) begin
                            n_col = '0;
                            if (({1'b0, r_row} + 9'd1) >= {1'b0, r_height}) begin
                                n_row     = '0;
                                n_phase   = PH_IDLE;
                                n_s1_kind = K_DONE;
                            end else begin
                                n_row     = r_row + 8'd1;
                                n_phase   = PH_PIXELS;
                                n_s1_kind = K_EMPTY;
                            end
                        end else begin
                            n_replay  = '0;
                            n_phase   = PH_REPLAY;
                            n_s1_kind = K_EMPTY;
                        end
                    end
                end
                REQ_TICK: begin
                    if (r_phase == PH_REPLAY && int'(r_replay) < ROW_CAPACITY) begin
                        w_ram_re      = 1'b1;
                        n_s1_kind     = K_COLOUR;
                        n_s1_from_ram = 1'b1;
                        if (({1'b0, r_replay} + 9'd1) >= {1'b0, r_width}) begin
                            n_s1_trailer = 1'b1;
                            n_replay     = '0;
                            n_phase      = PH_ROW_WAIT;
                        end else begin
                            n_replay = r_replay + ROW_AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_col      <= '0;
            r_replay   <= '0;
            r_row      <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_channel  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_col      <= n_col;
            r_replay   <= n_replay;
            r_row      <= n_row;
            r_width    <= n_width;
            r_height   <= n_height;
            r_channel  <= n_channel;
            r_s1_valid <= n_s1_valid;
        end
        r_s1_kind     <= n_s1_kind;
        r_s1_hdr      <= n_s1_hdr;
        r_s1_rgb      <= n_s1_rgb;
        r_s1_from_ram <= n_s1_from_ram;
        r_s1_trailer  <= n_s1_trailer;
        r_s1_end      <= n_s1_end;
    end

    ifs_ram #(
        .WIDTH (24),
        .DEPTH (ROW_CAPACITY)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_col),
        .i_wdata (w_rgb),
        .i_re    (w_ram_re),
        .i_raddr (r_replay),
        .o_rdata (w_ram_rdata)
    );

    // byte list build
    always_comb begin
        unique case (r_s1_kind)
            K_HEADER: w_job = ifs_header_job(r_s1_hdr);
            K_COLOUR: w_job = ifs_colour_job(r_s1_from_ram ? w_ram_rdata : r_s1_rgb,
                                             r_s1_trailer, r_func_code, r_s1_end);
            K_EMPTY:  w_job = ifs_single_job(1'b0, 1'b0);
            K_DONE:   w_job = ifs_single_job(1'b0, 1'b1);
            default:  w_job = ifs_single_job(1'b1, 1'b0);
        endcase
    end

    ifs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_s1_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase not one-hot");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> ({1'b0, r_col} < {1'b0, r_width}))
        else $error("column beyond row width");

    a_replay_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REPLAY) |-> ({1'b0, r_replay} < {1'b0, r_width}))
        else $error("replay index beyond row width");

    a_tick_reads_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> (r_s1_valid && r_s1_from_ram && r_s1_kind == K_COLOUR))
        else $error("replay read not followed by colour list");

endmodule

// ----- rtl/ifs_ram.sv -----
// ----------------------------------------------------------------------------
// ifs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ifs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ifs_emit.sv -----
// ----------------------------------------------------------------------------
// ifs_emit
// output sequencer: holds one byte list; while m_tready is high, one transaction per cycle
// ----------------------------------------------------------------------------
module ifs_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  ifs_pkg::t_job                       i_job,
    output logic                                o_job_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ifs_pkg::M_TDATA_W-1:0]       m_tdata,  // tx_byte
    output logic [ifs_pkg::M_TUSER_W-1:0]       m_tuser,  // tx_valid, rejected, image_done
    output logic                                m_tlast
);
    import ifs_pkg::*;

    t_job              r_job;
    logic              r_busy;
    logic [RES_IW-1:0] r_idx;
    t_job              n_job;
    logic              n_busy;
    logic [RES_IW-1:0] n_idx;
    logic              w_last;
    logic              w_done;

    assign w_last      = ({1'b0, r_idx} + RES_CW'(1)) == r_job.count;
    assign w_done      = r_busy && m_tready && w_last;
    assign o_job_ready = !r_busy || w_done;

    always_comb begin
        n_job  = r_job;
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_job_ready) begin
            n_busy = i_job_valid;
            n_idx  = '0;
            if (i_job_valid) begin
                n_job = i_job;
            end
        end else if (m_tready) begin
            n_idx = r_idx + RES_IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_job <= n_job;
    end

    assign m_tvalid = r_busy;
    assign m_tdata  = r_job.bytes[r_idx];
    assign m_tuser  = {r_job.image_done, r_job.rejected, r_job.tx_valid};
    assign m_tlast  = w_last;

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.count != '0 && {1'b0, r_idx} < r_job.count))
        else $error("emit index outside byte list");

    a_no_byte_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.tx_valid) |-> (r_job.count == RES_CW'(1) && r_job.bytes[0] == '0))
        else $error("empty result not a single zero byte");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && m_tready && !w_last) |=> (r_busy && r_idx == $past(r_idx) + RES_IW'(1)))
        else $error("emit index did not advance");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for image_frame_sender_core: a queue of start, pixel,
// reply and replay requests feeds the slave stream, a behavioral model of the
// sender predicts every output byte, and the master stream is checked field by
// field under random stalls on both sides and five settings of the code regs
// ----------------------------------------------------------------------------
module tb;
    import ifs_pkg::*;

    typedef struct packed {
        t_req        req;
        logic [7:0]  channel;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [23:0] rgb;
        logic [7:0]  rx;
    } t_send_req;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       rej;
        logic       done;
    } t_tx_byte;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]    i_cfg_index = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;

    image_frame_sender_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sender model state
    t_phase      send_phase = PH_IDLE;
    logic [23:0] row_mem [ROW_CAPACITY];
    logic [7:0]  col_pos    = '0;
    logic [7:0]  row_pos    = '0;
    logic [7:0]  img_w      = '0;
    logic [7:0]  img_h      = '0;
    logic [7:0]  img_ch     = '0;
    logic [7:0]  replay_pos = '0;
    logic [7:0]  ack_val    = 8'd6;
    logic [7:0]  func_val   = 8'd170;
    logic [7:0]  end_img_val = 8'd1;
    logic [7:0]  end_row_val = 8'd2;

    t_send_req pending_reqs [$];
    t_tx_byte  outgoing_bytes [$];
    t_send_req cur_req;

    int  mismatch_count    = 0;
    int  requests_accepted = 0;
    int  bytes_checked     = 0;
    int  images_done       = 0;
    int  random_items      = 0;
    bit  calm              = 1'b0;
    bit  want_hold         = 1'b0;
    bit  hold_taken        = 1'b0;
    int  hold_left         = 0;

    function automatic t_tx_byte make_byte(input logic [7:0] d, input logic v,
                                           input logic rj, input logic dn);
        t_tx_byte b;
        b.data  = d;
        b.valid = v;
        b.last  = 1'b0;
        b.rej   = rj;
        b.done  = dn;
        return b;
    endfunction

    task automatic add_colour(input logic [23:0] rgb);
        logic [7:0] c;
        for (int k = 2; k >= 0; k--) begin
            c = rgb[k*8 +: 8];
            outgoing_bytes.push_back(make_byte(c, 1'b1, 1'b0, 1'b0));
            if (c == ESCAPE_BYTE)
                outgoing_bytes.push_back(make_byte(c, 1'b1, 1'b0, 1'b0));
        end
    endtask

    task automatic add_trailer();
        outgoing_bytes.push_back(make_byte(func_val, 1'b1, 1'b0, 1'b0));
        if ({1'b0, row_pos} + 9'd1 == {1'b0, img_h})
            outgoing_bytes.push_back(make_byte(end_img_val, 1'b1, 1'b0, 1'b0));
        else
            outgoing_bytes.push_back(make_byte(end_row_val, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic add_header();
        outgoing_bytes.push_back(make_byte(img_ch, 1'b1, 1'b0, 1'b0));
        outgoing_bytes.push_back(make_byte(img_w, 1'b1, 1'b0, 1'b0));
        outgoing_bytes.push_back(make_byte(img_h, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic predict_sender(input t_send_req rq);
        logic reject;
        reject = 1'b0;
        case (rq.req)
            REQ_START: begin
                if (send_phase != PH_IDLE || rq.width == 8'd0 || rq.height == 8'd0) begin
                    reject = 1'b1;
                end else begin
                    img_ch     = rq.channel;
                    img_w      = rq.width;
                    img_h      = rq.height;
                    col_pos    = '0;
                    row_pos    = '0;
                    replay_pos = '0;
                    add_header();
                    send_phase = PH_HDR_WAIT;
                end
            end
            REQ_PIXEL: begin
                if (send_phase != PH_PIXELS) begin
                    reject = 1'b1;
                end else begin
                    row_mem[col_pos] = rq.rgb;
                    add_colour(rq.rgb);
                    if ({1'b0, col_pos} + 9'd1 >= {1'b0, img_w}) begin
                        add_trailer();
                        col_pos    = '0;
                        send_phase = PH_ROW_WAIT;
                    end else begin
                        col_pos = col_pos + 8'd1;
                    end
                end
            end
            REQ_REPLY: begin
                if (send_phase == PH_HDR_WAIT) begin
                    if (rq.rx == ack_val) begin
                        col_pos    = '0;
                        row_pos    = '0;
                        send_phase = PH_PIXELS;
                        outgoing_bytes.push_back(make_byte(8'd0, 1'b0, 1'b0, 1'b0));
                    end else begin
                        add_header();
                    end
                end else if (send_phase == PH_ROW_WAIT) begin
                    if (rq.rx == ack_val) begin
                        col_pos = '0;
                        if ({1'b0, row_pos} + 9'd1 >= {1'b0, img_h}) begin
                            row_pos    = '0;
                            send_phase = PH_IDLE;
                            outgoing_bytes.push_back(make_byte(8'd0, 1'b0, 1'b0, 1'b1));
                        end else begin
                            row_pos    = row_pos + 8'd1;
                            send_phase = PH_PIXELS;
                            outgoing_bytes.push_back(make_byte(8'd0, 1'b0, 1'b0, 1'b0));
                        end
                    end else begin
                        replay_pos = '0;
                        send_phase = PH_REPLAY;
                        outgoing_bytes.push_back(make_byte(8'd0, 1'b0, 1'b0, 1'b0));
                    end
                end else begin
                    reject = 1'b1;
                end
            end
            default: begin
                if (send_phase != PH_REPLAY) begin
                    reject = 1'b1;
                end else begin
                    add_colour(row_mem[replay_pos]);
                    if ({1'b0, replay_pos} + 9'd1 >= {1'b0, img_w}) begin
                        add_trailer();
                        replay_pos = '0;
                        send_phase = PH_ROW_WAIT;
                    end else begin
                        replay_pos = replay_pos + 8'd1;
                    end
                end
            end
        endcase
        if (reject)
            outgoing_bytes.push_back(make_byte(8'd0, 1'b0, 1'b1, 1'b0));
        outgoing_bytes[outgoing_bytes.size()-1].last = 1'b1;
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 22);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_sender(cur_req);
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && !idle_now()) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_req.rx, cur_req.rgb, cur_req.height,
                                 cur_req.width, cur_req.channel};
                    s_tuser  <= cur_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (want_hold && !hold_taken) begin
            hold_left  <= 80;
            hold_taken <= 1'b1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= !idle_now();
        end
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("tb: mismatch %0d at %0t: %s", mismatch_count, $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_tx_byte want;
        if (i_rst_n && m_tvalid && m_tready) begin
            bytes_checked++;
            if (m_tuser[2] === 1'b1)
                images_done++;
            if (outgoing_bytes.size() == 0) begin
                flag_error($sformatf("unexpected byte %0h", m_tdata));
            end else begin
                want = outgoing_bytes.pop_front();
                check_field("tx_byte", m_tdata, want.data);
                check_field("tx_valid", 8'(m_tuser[0]), 8'(want.valid));
                check_field("last", 8'(m_tlast), 8'(want.last));
                check_field("rejected", 8'(m_tuser[1]), 8'(want.rej));
                check_field("image_done", 8'(m_tuser[2]), 8'(want.done));
            end
        end
    end

    task automatic add_req(input t_req kind, input logic [7:0] ch, input logic [7:0] w,
                           input logic [7:0] h, input logic [23:0] rgb,
                           input logic [7:0] rx, input bit counted);
        t_send_req rq;
        rq.req     = kind;
        rq.channel = ch;
        rq.width   = w;
        rq.height  = h;
        rq.rgb     = rgb;
        rq.rx      = rx;
        pending_reqs.push_back(rq);
        if (counted)
            random_items++;
    endtask

    function automatic logic [7:0] rand_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return ESCAPE_BYTE;
        else if (roll < 32)
            return 8'h00;
        else if (roll < 39)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] other_than_ack();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == ack_val);
        return v;
    endfunction

    // misplaced request with random content
    task automatic add_noise(input t_req kind);
        add_req(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 24'($urandom), 8'($urandom_range(255)), 1'b0);
    endtask

    task automatic queue_frame(input logic [7:0] w, input logic [7:0] h,
                               input bit allow_replay);
        t_req wrong_in_pixels [3];
        wrong_in_pixels = '{REQ_START, REQ_TICK, REQ_REPLY};
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(2))
                0: add_req(REQ_START, 8'($urandom_range(255)), 8'd0,
                           8'($urandom_range(255)), 24'($urandom), 8'($urandom_range(255)), 0);
                1: add_req(REQ_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'd0, 24'($urandom), 8'($urandom_range(255)), 0);
                default: add_noise(t_req'($urandom_range(1, 3)));
            endcase
        end
        add_req(REQ_START, rand_byte(), w, h, 24'($urandom), 8'($urandom_range(255)), 1);
        while ($urandom_range(99) < 30) begin
            if ($urandom_range(1))
                add_noise($urandom_range(1) ? REQ_PIXEL : REQ_TICK);
            add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'd0, other_than_ack(), 1);
        end
        add_req(REQ_REPLY, 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom),
                ack_val, 1);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(99) < 8)
                    add_noise(wrong_in_pixels[$urandom_range(2)]);
                add_req(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                        {rand_byte(), rand_byte(), rand_byte()}, 8'($urandom), 1);
            end
            while (allow_replay && $urandom_range(99) < 35) begin
                add_req(REQ_REPLY, 8'($urandom), 8'($urandom), 8'($urandom),
                        24'($urandom), other_than_ack(), 1);
                if ($urandom_range(99) < 20)
                    add_noise(REQ_PIXEL);
                for (int c = 0; c < w; c++)
                    add_req(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                            24'($urandom), 8'($urandom), 1);
                if ($urandom_range(99) < 25)
                    add_noise(REQ_TICK);
            end
            add_req(REQ_REPLY, 8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom),
                    ack_val, 1);
        end
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_ACK:       ack_val     = value;
            CFG_FUNCTION:  func_val    = value;
            CFG_END_IMAGE: end_img_val = value;
            default:       end_row_val = value;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_codes(input logic [7:0] ack, input logic [7:0] fn,
                               input logic [7:0] e_img, input logic [7:0] e_row);
        write_reg(CFG_ACK, ack);
        write_reg(CFG_FUNCTION, fn);
        write_reg(CFG_END_IMAGE, e_img);
        write_reg(CFG_END_ROW, e_row);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || s_tvalid || outgoing_bytes.size() != 0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic queue_small_images(input int count);
        int stop_at;
        stop_at = random_items + count;
        while (random_items < stop_at)
            queue_frame(8'($urandom_range(1, 6)), 8'($urandom_range(1, 3)), 1'b1);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, reset codes
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'hFFFFFF, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, ack_val, 0);
        add_req(REQ_START, 8'd1, 8'd0, 8'd5, 24'h000000, 8'd0, 0);
        add_req(REQ_START, 8'd2, 8'd3, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_START, ESCAPE_BYTE, 8'd2, 8'd2, 24'h000000, 8'd0, 0);
        add_req(REQ_START, 8'd0, 8'd1, 8'd1, 24'h000000, 8'd0, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'h123456, 8'd0, 0);
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, 8'hFF, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, ack_val, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'hFF00AA, 8'd0, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'hAAAAAA, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, 8'h00, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'h654321, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, ack_val, 0);
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, ack_val, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        add_req(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 24'h55AA55, 8'd0, 0);
        add_req(REQ_REPLY, 8'd0, 8'd0, 8'd0, 24'h000000, ack_val, 0);
        add_req(REQ_TICK,  8'd0, 8'd0, 8'd0, 24'h000000, 8'd0, 0);
        wait_drained();

        // low codes
        write_codes(8'h00, 8'h00, 8'h00, 8'h00);
        queue_small_images(50);
        wait_drained();

        // high codes, one wide row, no idling and a long receiver hold-off
        write_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        calm      = 1'b1;
        want_hold = 1'b1;
        queue_frame(8'($urandom_range(128, 160)), 8'd1, 1'b0);
        queue_frame(8'd3, 8'd2, 1'b1);
        wait_drained();
        calm = 1'b0;

        // mixed codes, escape value as function code
        write_codes(8'($urandom_range(255)), ESCAPE_BYTE, 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        queue_small_images(30);
        wait_drained();

        write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), ESCAPE_BYTE);
        queue_small_images(30);
        wait_drained();

        $display("tb: %0d requests accepted, %0d output bytes checked, %0d images finished",
                 requests_accepted, bytes_checked, images_done);
        $display("tb: covered escaped bytes, header resends, row replays, misplaced requests");
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: timeout");
        $display("tb: errors");
        $finish;
    end

endmodule
